[sv/pao_pkg.sv]
package pao_pkg;

   localparam int COORD_WIDTH_DEF   = 16;
   localparam int MAX_VERTICES_DEF  = 65536;
   localparam int AREA_W            = 48;
   localparam int TURN_W            = 52;
   localparam int QUEUE_DEPTH       = 4;
   localparam int MIN_POLY_VERTICES = 3;

   // Coordinates carried from the front part to the back part for each vertex.
   localparam int NUM_COORDS = 10;
   localparam int C_X  = 0;
   localparam int C_Y  = 1;
   localparam int C_PX = 2;
   localparam int C_PY = 3;
   localparam int C_OX = 4;
   localparam int C_OY = 5;
   localparam int C_FX = 6;
   localparam int C_FY = 7;
   localparam int C_SX = 8;
   localparam int C_SY = 9;

   localparam int NUM_PRODUCTS = 10;

   typedef struct packed {
      logic add_area;
      logic add_turn;
      logic last;
      logic close_ok;
      logic over;
   } pao_flags_type;

endpackage

[sv/pao_req_if.sv]
interface pao_req_if #(
   parameter int COORD_WIDTH = pao_pkg::COORD_WIDTH_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] vertex_x;
   logic signed [COORD_WIDTH-1:0] vertex_y;
   logic                          last_vertex;

   modport source (output valid, vertex_x, vertex_y, last_vertex, input ready);
   modport sink   (input valid, vertex_x, vertex_y, last_vertex, output ready);
endinterface

[sv/pao_rsp_if.sv]
interface pao_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [pao_pkg::AREA_W-1:0] area;
   logic                              counter_clockwise;
   logic                              too_many_vertices;

   modport source (output valid, area, counter_clockwise, too_many_vertices, input ready);
   modport sink   (input valid, area, counter_clockwise, too_many_vertices, output ready);
endinterface

[sv/pao_queue.sv]
module pao_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = pao_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

[sv/pao_front.sv]
module pao_front #(
   parameter int COORD_WIDTH  = pao_pkg::COORD_WIDTH_DEF,
   parameter int MAX_VERTICES = pao_pkg::MAX_VERTICES_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   pao_req_if.sink                 req_chan,
   input  logic                    q_full,
   output logic                    q_push,
   output logic [pao_pkg::NUM_COORDS-1:0][COORD_WIDTH-1:0] q_coords,
   output pao_pkg::pao_flags_type  q_flags
);
   localparam int CNT_W = $clog2(MAX_VERTICES + 2);

   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       total;
   logic [COORD_WIDTH-1:0] first_x_ff, first_y_ff, second_x_ff, second_y_ff;
   logic [COORD_WIDTH-1:0] prev_x_ff, prev_y_ff, older_x_ff, older_y_ff;
   logic                   accept;
   logic                   in_bound;

   assign req_chan.ready = !q_full;
   assign accept         = req_chan.valid && !q_full;
   assign q_push         = accept;
   assign in_bound       = (count_ff < CNT_W'(MAX_VERTICES));

   // The count saturates one past the bound so that an overlong polygon stays flagged.
   always_comb begin
      total = (count_ff <= CNT_W'(MAX_VERTICES)) ? count_ff + 1'b1 : count_ff;
      count_in = count_ff;
      if (accept) begin
         count_in = req_chan.last_vertex ? '0 : total;
      end
   end

   always_comb begin
      q_flags.add_area = in_bound && (count_ff >= CNT_W'(1));
      q_flags.add_turn = in_bound && (count_ff >= CNT_W'(2));
      q_flags.last     = req_chan.last_vertex;
      q_flags.over     = (total > CNT_W'(MAX_VERTICES));
      q_flags.close_ok = !q_flags.over && (total >= CNT_W'(pao_pkg::MIN_POLY_VERTICES));

      q_coords[pao_pkg::C_X]  = req_chan.vertex_x;
      q_coords[pao_pkg::C_Y]  = req_chan.vertex_y;
      q_coords[pao_pkg::C_PX] = prev_x_ff;
      q_coords[pao_pkg::C_PY] = prev_y_ff;
      q_coords[pao_pkg::C_OX] = older_x_ff;
      q_coords[pao_pkg::C_OY] = older_y_ff;
      q_coords[pao_pkg::C_FX] = first_x_ff;
      q_coords[pao_pkg::C_FY] = first_y_ff;
      q_coords[pao_pkg::C_SX] = second_x_ff;
      q_coords[pao_pkg::C_SY] = second_y_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && in_bound) begin
         if (count_ff == '0) begin
            first_x_ff <= req_chan.vertex_x;
            first_y_ff <= req_chan.vertex_y;
         end
         if (count_ff == CNT_W'(1)) begin
            second_x_ff <= req_chan.vertex_x;
            second_y_ff <= req_chan.vertex_y;
         end
         older_x_ff <= prev_x_ff;
         older_y_ff <= prev_y_ff;
         prev_x_ff  <= req_chan.vertex_x;
         prev_y_ff  <= req_chan.vertex_y;
      end
   end
endmodule

[sv/pao_back.sv]
module pao_back #(
   parameter int COORD_WIDTH = pao_pkg::COORD_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_empty,
   output logic                   q_pop,
   input  logic [pao_pkg::NUM_COORDS-1:0][COORD_WIDTH-1:0] q_coords,
   input  pao_pkg::pao_flags_type q_flags,
   pao_rsp_if.source              rsp_chan
);
   localparam int DW = COORD_WIDTH + 1;
   localparam int PW = 2 * DW;
   localparam int NP = pao_pkg::NUM_PRODUCTS;
   localparam int AW = pao_pkg::AREA_W;
   localparam int TW = pao_pkg::TURN_W;

   function automatic logic signed [DW-1:0] ext(input logic [COORD_WIDTH-1:0] v);
      return $signed({v[COORD_WIDTH-1], v});
   endfunction

   logic                   adv;
   logic [COORD_WIDTH-1:0] x, y, px, py, ox, oy, fx, fy, sx, sy;
   logic signed [DW-1:0]   op_a [NP];
   logic signed [DW-1:0]   op_b [NP];
   logic signed [PW-1:0]   prod_in [NP];

   logic                   s1_valid_ff;
   pao_pkg::pao_flags_type s1_flags_ff;
   logic signed [PW-1:0]   prod_ff [NP];

   logic                   s2_valid_ff;
   pao_pkg::pao_flags_type s2_flags_ff;
   logic [AW-1:0]          a_term_ff, a_term_in, ca_ff, ca_in;
   logic [TW-1:0]          t_term_ff, t_term_in, ct_ff, ct_in;

   logic [AW-1:0]          area_sum_ff, a_new;
   logic [TW-1:0]          turn_sum_ff, t_new;
   logic                   fin_valid_ff;
   pao_pkg::pao_flags_type fin_flags_ff;
   logic [AW-1:0]          fin_area_ff;
   logic [TW-1:0]          fin_turn_ff;

   logic [AW-1:0]          rounded, halved;
   logic                   rsp_valid_ff;
   logic [AW-1:0]          rsp_area_ff;
   logic                   rsp_ccw_ff, rsp_over_ff;

   // The whole back pipeline moves together and holds while a result waits.
   assign adv   = !rsp_valid_ff || rsp_chan.ready;
   assign q_pop = adv && !q_empty;

   always_comb begin
      x  = q_coords[pao_pkg::C_X];
      y  = q_coords[pao_pkg::C_Y];
      px = q_coords[pao_pkg::C_PX];
      py = q_coords[pao_pkg::C_PY];
      ox = q_coords[pao_pkg::C_OX];
      oy = q_coords[pao_pkg::C_OY];
      fx = q_coords[pao_pkg::C_FX];
      fy = q_coords[pao_pkg::C_FY];
      sx = q_coords[pao_pkg::C_SX];
      sy = q_coords[pao_pkg::C_SY];

      // Shoelace term of the previous and current vertex.
      op_a[0] = ext(px);            op_b[0] = ext(y);
      op_a[1] = ext(py);            op_b[1] = ext(x);
      // Turn of the older, previous and current vertex.
      op_a[2] = ext(px) - ext(ox);  op_b[2] = ext(y) - ext(oy);
      op_a[3] = ext(py) - ext(oy);  op_b[3] = ext(x) - ext(ox);
      // Closing shoelace term, current vertex back to the first.
      op_a[4] = ext(x);             op_b[4] = ext(fy);
      op_a[5] = ext(y);             op_b[5] = ext(fx);
      // Closing turns through the first vertex and then the second.
      op_a[6] = ext(x) - ext(px);   op_b[6] = ext(fy) - ext(py);
      op_a[7] = ext(y) - ext(py);   op_b[7] = ext(fx) - ext(px);
      op_a[8] = ext(fx) - ext(x);   op_b[8] = ext(sy) - ext(y);
      op_a[9] = ext(fy) - ext(y);   op_b[9] = ext(sx) - ext(x);

      for (int i = 0; i < NP; i++) begin
         prod_in[i] = op_a[i] * op_b[i];
      end
   end

   always_comb begin
      a_term_in = s1_flags_ff.add_area ? AW'(prod_ff[0]) - AW'(prod_ff[1]) : '0;
      t_term_in = s1_flags_ff.add_turn ? TW'(prod_ff[2]) - TW'(prod_ff[3]) : '0;
      ca_in     = AW'(prod_ff[4]) - AW'(prod_ff[5]);
      ct_in     = TW'(prod_ff[6]) - TW'(prod_ff[7]) + TW'(prod_ff[8]) - TW'(prod_ff[9]);
   end

   assign a_new = area_sum_ff + a_term_ff;
   assign t_new = turn_sum_ff + t_term_ff;

   // An arithmetic shift rounds toward minus infinity, so a negative sum is nudged up by one first.
   assign rounded = fin_area_ff + AW'(fin_area_ff[AW-1]);
   assign halved  = {rounded[AW-1], rounded[AW-1:1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         fin_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         area_sum_ff  <= '0;
         turn_sum_ff  <= '0;
      end else if (adv) begin
         s1_valid_ff  <= !q_empty;
         s2_valid_ff  <= s1_valid_ff;
         fin_valid_ff <= s2_valid_ff && s2_flags_ff.last;
         rsp_valid_ff <= fin_valid_ff;
         if (s2_valid_ff) begin
            if (s2_flags_ff.last) begin
               area_sum_ff <= '0;
               turn_sum_ff <= '0;
            end else begin
               area_sum_ff <= a_new;
               turn_sum_ff <= t_new;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_flags_ff  <= q_flags;
         prod_ff      <= prod_in;
         s2_flags_ff  <= s1_flags_ff;
         a_term_ff    <= a_term_in;
         t_term_ff    <= t_term_in;
         ca_ff        <= ca_in;
         ct_ff        <= ct_in;
         fin_flags_ff <= s2_flags_ff;
         fin_area_ff  <= a_new + ca_ff;
         fin_turn_ff  <= t_new + ct_ff;
         rsp_area_ff  <= fin_flags_ff.close_ok ? halved : '0;
         rsp_ccw_ff   <= fin_flags_ff.close_ok && !fin_turn_ff[TW-1] && (fin_turn_ff != '0);
         rsp_over_ff  <= fin_flags_ff.over;
      end
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.area              = $signed(rsp_area_ff);
   assign rsp_chan.counter_clockwise = rsp_ccw_ff;
   assign rsp_chan.too_many_vertices = rsp_over_ff;
endmodule

[sv/polygon_area_orientation.sv]
// Channel    Dir  Beat contents
// req_chan   in   vertex_x, vertex_y, last_vertex
// rsp_chan   out  area, counter_clockwise, too_many_vertices
//
// One vertex is taken per cycle while the queue has room. A polygon's result is
// offered once its last vertex has passed the vertex queue and the product, term
// and closing stages, with the halving done on the way into the output register.
// Reset is synchronous and clears the vertex count, queue and accumulators.
// A stalled result holds the back end; the front keeps taking vertices until
// the four-entry vertex queue fills.
module polygon_area_orientation #(
   parameter int COORD_WIDTH  = pao_pkg::COORD_WIDTH_DEF,
   parameter int MAX_VERTICES = pao_pkg::MAX_VERTICES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   pao_req_if.sink    req_chan,
   pao_rsp_if.source  rsp_chan
);
   localparam int ITEM_W = pao_pkg::NUM_COORDS * COORD_WIDTH
                           + $bits(pao_pkg::pao_flags_type);

   logic [pao_pkg::NUM_COORDS-1:0][COORD_WIDTH-1:0] f_coords, b_coords;
   pao_pkg::pao_flags_type f_flags, b_flags;
   logic [ITEM_W-1:0]      q_in, q_out;
   logic                   q_push, q_pop, q_full, q_empty;

   pao_front #(
      .COORD_WIDTH  (COORD_WIDTH),
      .MAX_VERTICES (MAX_VERTICES)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_coords (f_coords),
      .q_flags  (f_flags)
   );

   assign q_in = {f_flags, f_coords};

   pao_queue #(
      .WIDTH (ITEM_W),
      .DEPTH (pao_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_out),
      .empty     (q_empty)
   );

   assign {b_flags, b_coords} = q_out;

   pao_back #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_pop    (q_pop),
      .q_coords (b_coords),
      .q_flags  (b_flags),
      .rsp_chan (rsp_chan)
   );

   a_over_gives_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.too_many_vertices)
         |-> (rsp_chan.area == '0 && !rsp_chan.counter_clockwise))
      else $error("overlong polygon reported a non-zero result");

   a_area_halved: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid
         |-> (rsp_chan.area[pao_pkg::AREA_W-1] == rsp_chan.area[pao_pkg::AREA_W-2]))
      else $error("area exceeds the range of a halved sum");

   a_quiet_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_chan.valid)
      else $error("result beat offered straight after reset");
endmodule

[bench/polygon_area_orientation_tb.sv]
module polygon_area_orientation_tb;

   localparam int COORD_W         = pao_pkg::COORD_WIDTH_DEF;
   localparam int MAX_VERTS       = pao_pkg::MAX_VERTICES_DEF;
   localparam int RANDOM_VERTICES = 930;
   localparam int CYCLE_LIMIT     = 200000;
   localparam int STALL_CYCLES    = 90;
   localparam int DRAIN_CYCLES    = 20;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct {
      logic signed [pao_pkg::AREA_W-1:0] area;
      logic                              ccw;
      logic                              over;
   } polygon_result_type;

   typedef enum int {SPREAD_FULL, SPREAD_NEAR, SPREAD_CORNERS} coord_spread_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pao_req_if #(.COORD_WIDTH(COORD_W)) req_chan ();
   pao_rsp_if rsp_chan ();

   polygon_area_orientation #(
      .COORD_WIDTH  (COORD_W),
      .MAX_VERTICES (MAX_VERTS)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Running polygon state, mirroring what the block keeps.
   coord_type                  first_x, first_y, second_x, second_y;
   coord_type                  prev_x, prev_y, older_x, older_y;
   logic [pao_pkg::AREA_W-1:0] area_acc;
   logic [pao_pkg::TURN_W-1:0] turn_acc;
   int unsigned                count_seen;

   polygon_result_type expected_areas[$];
   int                 errors = 0;
   int                 cycle_count = 0;
   int                 stall_left;
   logic               steady;

   function automatic longint cross_term(coord_type ax, coord_type ay,
                                         coord_type bx, coord_type by);
      return longint'(ax) * longint'(by) - longint'(ay) * longint'(bx);
   endfunction

   function automatic longint turn_term(coord_type ax, coord_type ay, coord_type bx,
                                        coord_type by, coord_type cx, coord_type cy);
      return (longint'(bx) - longint'(ax)) * (longint'(cy) - longint'(ay))
           - (longint'(by) - longint'(ay)) * (longint'(cx) - longint'(ax));
   endfunction

   function automatic void clear_polygon();
      first_x = '0;  first_y = '0;  second_x = '0; second_y = '0;
      prev_x = '0;   prev_y = '0;   older_x = '0;  older_y = '0;
      area_acc = '0; turn_acc = '0; count_seen = 0;
   endfunction

   // Folds one accepted vertex into the running sums; a closing vertex yields a result.
   function automatic void fold_vertex(coord_type x, coord_type y, logic last);
      polygon_result_type                res;
      logic signed [pao_pkg::AREA_W-1:0] area_total;
      logic signed [pao_pkg::TURN_W-1:0] turn_total;
      int unsigned                       n;
      n = count_seen;
      if (n < MAX_VERTS) begin
         if (n == 0) begin
            first_x = x;
            first_y = y;
         end
         if (n == 1) begin
            second_x = x;
            second_y = y;
         end
         if (n >= 1)
            area_acc = area_acc + pao_pkg::AREA_W'(cross_term(prev_x, prev_y, x, y));
         if (n >= 2)
            turn_acc = turn_acc
               + pao_pkg::TURN_W'(turn_term(older_x, older_y, prev_x, prev_y, x, y));
         older_x = prev_x;
         older_y = prev_y;
         prev_x  = x;
         prev_y  = y;
      end
      if (n <= MAX_VERTS)
         count_seen = n + 1;
      if (last) begin
         res.area = '0;
         res.ccw  = 1'b0;
         res.over = count_seen > MAX_VERTS;
         if (!res.over && count_seen >= pao_pkg::MIN_POLY_VERTICES) begin
            area_total = area_acc
               + pao_pkg::AREA_W'(cross_term(prev_x, prev_y, first_x, first_y));
            turn_total = turn_acc
               + pao_pkg::TURN_W'(turn_term(older_x, older_y, prev_x, prev_y,
                                            first_x, first_y))
               + pao_pkg::TURN_W'(turn_term(prev_x, prev_y, first_x, first_y,
                                            second_x, second_y));
            // Signed division truncates toward zero, as the halved area must.
            res.area = area_total / 2;
            res.ccw  = turn_total > 0;
         end
         expected_areas.insert(expected_areas.size(), res);
         clear_polygon();
      end
   endfunction

   function automatic coord_type pick_coord(coord_spread_type spread);
      case (spread)
         SPREAD_FULL: return coord_type'($urandom);
         SPREAD_NEAR: return coord_type'(int'($urandom_range(40)) - 20);
         default: begin
            case ($urandom_range(4))
               0:       return {1'b1, {(COORD_W-1){1'b0}}};
               1:       return {1'b0, {(COORD_W-1){1'b1}}};
               2:       return '0;
               3:       return '1;
               default: return coord_type'($urandom);
            endcase
         end
      endcase
   endfunction

   task automatic send_vertex(input coord_type x, input coord_type y, input logic last);
      while (!steady && $urandom_range(99) < 36) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.vertex_x    <= x;
      req_chan.vertex_y    <= y;
      req_chan.last_vertex <= last;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      fold_vertex(x, y, last);
   endtask

   task automatic send_random_polygon(input int n, input coord_spread_type spread);
      for (int i = 0; i < n; i++)
         send_vertex(pick_coord(spread), pick_coord(spread), i == n - 1);
   endtask

   task automatic test_short_polygons;
      send_vertex(16'sh7fff, -16'sh8000, 1'b1);
      send_vertex(-16'sh8000, -16'sh8000, 1'b0);
      send_vertex(16'sh7fff, 16'sh7fff, 1'b1);
   endtask

   task automatic test_orientation;
      send_vertex(16'sd0, 16'sd0, 1'b0);
      send_vertex(16'sd10, 16'sd0, 1'b0);
      send_vertex(16'sd0, 16'sd10, 1'b1);
      // Odd doubled areas check truncation toward zero in both directions.
      send_vertex(16'sd0, 16'sd0, 1'b0);
      send_vertex(16'sd3, 16'sd0, 1'b0);
      send_vertex(16'sd0, 16'sd1, 1'b1);
      send_vertex(16'sd0, 16'sd0, 1'b0);
      send_vertex(16'sd0, 16'sd1, 1'b0);
      send_vertex(16'sd3, 16'sd0, 1'b1);
      // Collinear points turn neither way.
      send_vertex(16'sd0, 16'sd0, 1'b0);
      send_vertex(16'sd1, 16'sd1, 1'b0);
      send_vertex(16'sd2, 16'sd2, 1'b1);
   endtask

   task automatic test_extreme_coordinates;
      send_vertex(-16'sh8000, -16'sh8000, 1'b0);
      send_vertex(16'sh7fff, -16'sh8000, 1'b0);
      send_vertex(16'sh7fff, 16'sh7fff, 1'b0);
      send_vertex(-16'sh8000, 16'sh7fff, 1'b1);
      send_vertex(16'sh7fff, 16'sh7fff, 1'b0);
      send_vertex(16'sh7fff, -16'sh8000, 1'b0);
      send_vertex(-16'sh8000, -16'sh8000, 1'b1);
   endtask

   task automatic test_long_polygons;
      send_random_polygon(24, SPREAD_FULL);
      send_random_polygon(40, SPREAD_CORNERS);
   endtask

   // The result side holds off while triangles keep coming, so the vertex queue fills.
   task automatic test_output_backpressure;
      while (stall_left != 0)
         @(posedge clock);
      stall_left <= STALL_CYCLES;
      repeat (12)
         send_random_polygon(3, SPREAD_NEAR);
   endtask

   task automatic test_random_polygons;
      int sent;
      int n;
      int pick;
      sent = 0;
      while (sent < RANDOM_VERTICES) begin
         steady <= (sent >= 300 && sent < 550);
         pick = $urandom_range(99);
         if (pick < 6)
            n = $urandom_range(2, 1);
         else if (pick < 16)
            n = $urandom_range(30, 9);
         else
            n = $urandom_range(8, 3);
         send_random_polygon(n, coord_spread_type'($urandom_range(2)));
         sent += n;
      end
      steady <= 1'b0;
   endtask

   always @(posedge clock) begin
      if (stall_left != 0)
         stall_left <= stall_left - 1;
   end

   always @(posedge clock) begin : result_check
      polygon_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_areas.size() == 0) begin
            $error("result beat with none expected: area %0d", rsp_chan.area);
            errors++;
         end else begin
            want = expected_areas.pop_front();
            if (rsp_chan.area !== want.area) begin
               $error("area: expected %0d, got %0d", want.area, rsp_chan.area);
               errors++;
            end
            if (rsp_chan.counter_clockwise !== want.ccw) begin
               $error("counter_clockwise: expected %0b, got %0b",
                      want.ccw, rsp_chan.counter_clockwise);
               errors++;
            end
            if (rsp_chan.too_many_vertices !== want.over) begin
               $error("too_many_vertices: expected %0b, got %0b",
                      want.over, rsp_chan.too_many_vertices);
               errors++;
            end
         end
      end
      rsp_chan.ready <= (stall_left == 0) && (steady || $urandom_range(99) >= 36);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      req_chan.valid       = 1'b0;
      req_chan.vertex_x    = '0;
      req_chan.vertex_y    = '0;
      req_chan.last_vertex = 1'b0;
      rsp_chan.ready       = 1'b0;
      steady               = 1'b0;
      stall_left           = 0;
      clear_polygon();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_short_polygons();
      test_orientation();
      test_extreme_coordinates();
      test_long_polygons();
      test_output_backpressure();
      test_random_polygons();

      req_chan.valid <= 1'b0;
      while (expected_areas.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

[polygon_area_orientation.f]
sv/pao_pkg.sv
sv/pao_req_if.sv
sv/pao_rsp_if.sv
sv/pao_queue.sv
sv/pao_front.sv
sv/pao_back.sv
sv/polygon_area_orientation.sv
bench/polygon_area_orientation_tb.sv
